FILE: sv/image_convolution_3x3_assert.svh
// ----------------------------------------------------------------------------
// Image convolution 3x3: assertion macros
// Property wrappers clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef IMAGE_CONVOLUTION_3X3_ASSERT_SVH
`define IMAGE_CONVOLUTION_3X3_ASSERT_SVH

// same-cycle implication
`define ICV_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ICV_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/icv_pkg.sv
// ----------------------------------------------------------------------------
// Image convolution 3x3: package
// Shared constants, register indexes, window and kernel types.
// ----------------------------------------------------------------------------
`default_nettype none

package icv_pkg;

   localparam int KERNEL_SIZE    = 3;
   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 4096;
   localparam int MIN_SIZE       = 3;
   localparam int RESET_WIDTH    = 1024;
   localparam int RESET_HEIGHT   = 768;

   localparam int PIXEL_W        = 8;
   localparam int LINE_W         = 2 * PIXEL_W;
   localparam int COEF_W         = 16;
   localparam int FRAC_BITS      = 8;
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = KERNEL_SIZE * COEF_W;

   localparam int PROD_W         = COEF_W + PIXEL_W + 1;
   localparam int ROWSUM_W       = PROD_W + 2;
   localparam int SUM_W          = ROWSUM_W + 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEF_TOP     = 3'd0,
      CSR_COEF_MID     = 3'd1,
      CSR_COEF_BOTTOM  = 3'd2,
      CSR_FRAME_WIDTH  = 3'd3,
      CSR_FRAME_HEIGHT = 3'd4
   } csr_index_type;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef pixel_type [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] window_type;
   typedef logic [COEF_W-1:0] coef_type;
   typedef coef_type [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0] kernel_type;

   // last valid index of a size saturated to MIN_SIZE..limit
   function automatic int unsigned last_index(int unsigned value, int unsigned limit);
      int unsigned res;
      if (value < MIN_SIZE) begin
         res = MIN_SIZE - 1;
      end else if (value > limit) begin
         res = limit - 1;
      end else begin
         res = value - 1;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: sv/icv_ram.sv
// ----------------------------------------------------------------------------
// Image convolution 3x3: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module icv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/icv_csr.sv
// ----------------------------------------------------------------------------
// Image convolution 3x3: control registers
// Kernel coefficients and saturated last column / last row.
// ----------------------------------------------------------------------------
`default_nettype none

module icv_csr #(
   parameter int MAX_WIDTH  = icv_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT = icv_pkg::MAX_HEIGHT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               wr_en,
   input  wire logic [icv_pkg::CSR_INDEX_W-1:0]    wr_index,
   input  wire logic [icv_pkg::CSR_DATA_W-1:0]     wr_data,
   output icv_pkg::kernel_type                     kernel,
   output logic      [$clog2(MAX_WIDTH)-1:0]       last_col,
   output logic      [$clog2(MAX_HEIGHT)-1:0]      last_row
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int K     = icv_pkg::KERNEL_SIZE;

   logic [icv_pkg::CSR_DATA_W-1:0] coef_ff [K];
   logic [icv_pkg::CSR_DATA_W-1:0] coef_in [K];
   logic [COL_W-1:0]               last_col_ff, last_col_in;
   logic [ROW_W-1:0]               last_row_ff, last_row_in;

   always_comb begin
      for (int k = 0; k < K; k++) begin
         coef_in[k] = coef_ff[k];
      end
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      if (wr_en) begin
         case (wr_index)
            icv_pkg::CSR_COEF_TOP:     coef_in[0] = wr_data;
            icv_pkg::CSR_COEF_MID:     coef_in[1] = wr_data;
            icv_pkg::CSR_COEF_BOTTOM:  coef_in[2] = wr_data;
            icv_pkg::CSR_FRAME_WIDTH: begin
               last_col_in = COL_W'(icv_pkg::last_index(
                  32'(wr_data[icv_pkg::FRAME_WIDTH_W-1:0]), MAX_WIDTH));
            end
            icv_pkg::CSR_FRAME_HEIGHT: begin
               last_row_in = ROW_W'(icv_pkg::last_index(
                  32'(wr_data[icv_pkg::FRAME_HEIGHT_W-1:0]), MAX_HEIGHT));
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < K; k++) begin
            coef_ff[k] <= '0;
         end
         last_col_ff <= COL_W'(icv_pkg::last_index(icv_pkg::RESET_WIDTH, MAX_WIDTH));
         last_row_ff <= ROW_W'(icv_pkg::last_index(icv_pkg::RESET_HEIGHT, MAX_HEIGHT));
      end else begin
         for (int k = 0; k < K; k++) begin
            coef_ff[k] <= coef_in[k];
         end
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
      end
   end

   always_comb begin
      for (int k = 0; k < K; k++) begin
         for (int l = 0; l < K; l++) begin
            kernel[k][l] = coef_ff[k][icv_pkg::COEF_W*l +: icv_pkg::COEF_W];
         end
      end
   end

   assign last_col = last_col_ff;
   assign last_row = last_row_ff;

endmodule

`default_nettype wire

FILE: sv/icv_mac.sv
// ----------------------------------------------------------------------------
// Image convolution 3x3: multiply-accumulate pipeline
// Nine products, row sums, final sum with floor shift and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

`include "image_convolution_3x3_assert.svh"

module icv_mac #(
   parameter int META_W = 23
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire icv_pkg::window_type          in_window,
   input  wire icv_pkg::kernel_type          in_kernel,
   input  wire logic [META_W-1:0]            in_meta,
   output logic                              in_free,
   output logic                              out_valid,
   input  wire logic                         out_stall,
   output logic      [icv_pkg::PIXEL_W-1:0]  out_pixel,
   output logic      [META_W-1:0]            out_meta
);

   localparam int K        = icv_pkg::KERNEL_SIZE;
   localparam int PROD_W   = icv_pkg::PROD_W;
   localparam int ROWSUM_W = icv_pkg::ROWSUM_W;
   localparam int SUM_W    = icv_pkg::SUM_W;
   localparam int FRAC     = icv_pkg::FRAC_BITS;
   localparam int PIX_W    = icv_pkg::PIXEL_W;

   logic                      s2_valid_ff, s2_valid_in;
   logic signed [PROD_W-1:0]  prod_ff [K][K];
   logic signed [PROD_W-1:0]  prod_in [K][K];
   logic [META_W-1:0]         s2_meta_ff;

   logic                      s3_valid_ff, s3_valid_in;
   logic signed [ROWSUM_W-1:0] rsum_ff [K];
   logic signed [ROWSUM_W-1:0] rsum_in [K];
   logic [META_W-1:0]         s3_meta_ff;

   logic                      out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]          out_pixel_ff, out_pixel_in;
   logic [META_W-1:0]         out_meta_ff;

   logic                      out_free, s3_free, s2_free, s3_go, s2_go;
   logic signed [SUM_W-1:0]   acc;

   assign out_free = !out_valid_ff || !out_stall;
   assign s3_free  = !s3_valid_ff || out_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign s3_go    = s3_valid_ff && out_free;
   assign s2_go    = s2_valid_ff && s3_free;
   assign in_free  = s2_free;

   always_comb begin
      for (int k = 0; k < K; k++) begin
         for (int l = 0; l < K; l++) begin
            prod_in[k][l] = PROD_W'($signed(in_kernel[k][l]))
                          * PROD_W'($signed({1'b0, in_window[k][l]}));
         end
      end
      for (int k = 0; k < K; k++) begin
         rsum_in[k] = ROWSUM_W'(prod_ff[k][0]) + ROWSUM_W'(prod_ff[k][1])
                    + ROWSUM_W'(prod_ff[k][2]);
      end
   end

   // floor shift by FRAC, clamp to pixel range
   always_comb begin
      acc = SUM_W'(rsum_ff[0]) + SUM_W'(rsum_ff[1]) + SUM_W'(rsum_ff[2]);
      if (acc[SUM_W-1]) begin
         out_pixel_in = '0;
      end else if (|acc[SUM_W-2:FRAC+PIX_W]) begin
         out_pixel_in = '1;
      end else begin
         out_pixel_in = acc[FRAC+PIX_W-1:FRAC];
      end
   end

   assign s2_valid_in  = in_valid || (s2_valid_ff && !s2_go);
   assign s3_valid_in  = s2_go || (s3_valid_ff && !s3_go);
   assign out_valid_in = s3_go || (out_valid_ff && out_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         prod_ff    <= prod_in;
         s2_meta_ff <= in_meta;
      end
      if (s2_go) begin
         rsum_ff    <= rsum_in;
         s3_meta_ff <= s2_meta_ff;
      end
      if (s3_go) begin
         out_pixel_ff <= out_pixel_in;
         out_meta_ff  <= s3_meta_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;
   assign out_meta  = out_meta_ff;

   `ICV_ASSERT_IMP(a_push_when_free, in_valid, in_free, "item pushed into full product stage")

endmodule

`default_nettype wire

FILE: sv/image_convolution_3x3.sv
// ----------------------------------------------------------------------------
// Image convolution 3x3
// Raster pixel stream through a two-line store and a 3x3 window; emits, for
// each interior pixel, the clamped kernel response with Q8.8 coefficients.
//
//   channel  dir  signals                                    transfer when
//   req      in   req_pixel_in                               valid & !stall
//   rsp      out  rsp_out_row rsp_out_col rsp_pixel_out      valid & !stall
//                 rsp_last
//   csr      in   csr_index csr_data                         valid & ready
//
// One pixel per cycle sustained while rsp_stall is low; the line store read
// shares the pixel's transfer edge, then products, row sums, and final sum
// with clamp are each registered in turn, the last in the output register,
// from which the result leaves once rsp_stall is low.
// Synchronous reset clears counters, window and pipeline valids; the line
// store is not cleared, its entries feed results only after being written.
// rsp_stall backs up through the pipeline; req_stall rises only when the
// first stage cannot drain.
// ----------------------------------------------------------------------------
`default_nettype none

`include "image_convolution_3x3_assert.svh"

module image_convolution_3x3 #(
   parameter int MAX_WIDTH  = icv_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT = icv_pkg::MAX_HEIGHT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [icv_pkg::PIXEL_W-1:0]       req_pixel_in,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [$clog2(MAX_HEIGHT)-1:0]     rsp_out_row,
   output logic      [$clog2(MAX_WIDTH)-1:0]      rsp_out_col,
   output logic      [icv_pkg::PIXEL_W-1:0]       rsp_pixel_out,
   output logic                                   rsp_last,

   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [icv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [icv_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int META_W = ROW_W + COL_W + 1;
   localparam int K      = icv_pkg::KERNEL_SIZE;
   localparam int PIX_W  = icv_pkg::PIXEL_W;
   localparam int LINE_W = icv_pkg::LINE_W;

   icv_pkg::kernel_type kernel;
   logic [COL_W-1:0]    last_col;
   logic [ROW_W-1:0]    last_row;

   logic                accept;
   logic                s1_go, s1_free, mac_free, mac_valid;
   logic [META_W-1:0]   mac_meta, rsp_meta;

   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                end_col, end_row;

   logic                s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]    s1_px_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic [ROW_W-1:0]    s1_row_ff;
   logic                s1_emit_ff, s1_emit_in;
   logic                s1_last_ff, s1_last_in;

   icv_pkg::window_type win_ff, win_in;

   logic                ram_rd_en, ram_wr_en;
   logic [COL_W-1:0]    ram_rd_addr, ram_wr_addr;
   logic [LINE_W-1:0]   ram_rd_data, ram_wr_data;

   assign csr_ready = 1'b1;

   icv_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .kernel   (kernel),
      .last_col (last_col),
      .last_row (last_row)
   );

   // stage 0: position, line store read
   assign s1_go     = s1_valid_ff && (!s1_emit_ff || mac_free);
   assign s1_free   = !s1_valid_ff || s1_go;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   assign end_col    = col_ff >= last_col;
   assign end_row    = row_ff >= last_row;
   assign s1_emit_in = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
   assign s1_last_in = end_col && end_row;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (end_col) begin
            col_in = '0;
            row_in = end_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_go);

   // consecutive pixels never share a column, and the write of one pixel
   // lands by the cycle the next one is read, so no forwarding is needed
   assign ram_rd_en   = accept;
   assign ram_rd_addr = col_ff;
   assign ram_wr_en   = s1_go;
   assign ram_wr_addr = s1_col_ff;
   assign ram_wr_data = {ram_rd_data[PIX_W-1:0], s1_px_ff};

   icv_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // stage 1: window shift
   always_comb begin
      for (int k = 0; k < K; k++) begin
         for (int l = 0; l < K - 1; l++) begin
            win_in[k][l] = win_ff[k][l+1];
         end
      end
      win_in[0][K-1] = ram_rd_data[LINE_W-1:PIX_W];
      win_in[1][K-1] = ram_rd_data[PIX_W-1:0];
      win_in[2][K-1] = s1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_go) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= req_pixel_in;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_emit_ff <= s1_emit_in;
         s1_last_ff <= s1_last_in;
      end
   end

   assign mac_valid = s1_go && s1_emit_ff;
   assign mac_meta  = {s1_row_ff - ROW_W'(1), s1_col_ff - COL_W'(1), s1_last_ff};

   icv_mac #(
      .META_W (META_W)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mac_valid),
      .in_window (win_in),
      .in_kernel (kernel),
      .in_meta   (mac_meta),
      .in_free   (mac_free),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_pixel (rsp_pixel_out),
      .out_meta  (rsp_meta)
   );

   assign rsp_out_row = rsp_meta[META_W-1:COL_W+1];
   assign rsp_out_col = rsp_meta[COL_W:1];
   assign rsp_last    = rsp_meta[0];

   `ICV_ASSERT_IMP(a_line_store_no_collision,
                   ram_rd_en && ram_wr_en, ram_rd_addr != ram_wr_addr,
                   "line store read and write hit one entry")
   `ICV_ASSERT_NXT(a_accept_fills_stage, accept, s1_valid_ff,
                   "transferred pixel missing from first stage")
   `ICV_ASSERT_IMP(a_interior_only,
                   rsp_valid, rsp_out_row != '0 && rsp_out_col != '0,
                   "border pixel emitted")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for image_convolution_3x3
// Streams raster pixels through the 3x3 filter and checks every interior
// result against an in-bench predictor that tracks the line store, window,
// position and kernel. Starts with short directed frames (size saturation,
// coefficient extremes, mid-frame resizing), then a long row at a width
// above range that is cut short, then random frames. Both sides idle and
// stall at random; register writes happen only once the block has drained.
// ----------------------------------------------------------------------------
module testbench;

   localparam int ROW_W         = $clog2(icv_pkg::MAX_HEIGHT);
   localparam int COL_W         = $clog2(icv_pkg::MAX_WIDTH);
   localparam int DATA_W        = icv_pkg::CSR_DATA_W;
   localparam int WIDE_PIXELS   = 400;
   localparam int RANDOM_PIXELS = 500;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      icv_pkg::pixel_type value;
      logic               last;
   } filtered_pixel_type;

   class pixel_filter_check;
      logic [DATA_W-1:0]     kernel_rows [icv_pkg::KERNEL_SIZE];
      int unsigned           width_raw;
      int unsigned           height_raw;
      icv_pkg::pixel_type    older_line [icv_pkg::MAX_WIDTH];
      icv_pkg::pixel_type    prior_line [icv_pkg::MAX_WIDTH];
      icv_pkg::pixel_type    win [icv_pkg::KERNEL_SIZE][icv_pkg::KERNEL_SIZE];
      int unsigned           col;
      int unsigned           row;
      filtered_pixel_type    due_pixels [$];
      int unsigned           bad_count;

      function new();
         foreach (kernel_rows[k]) kernel_rows[k] = '0;
         foreach (older_line[i]) begin
            older_line[i] = '0;
            prior_line[i] = '0;
         end
         foreach (win[k, l]) win[k][l] = '0;
         width_raw  = icv_pkg::RESET_WIDTH;
         height_raw = icv_pkg::RESET_HEIGHT;
         col        = 0;
         row        = 0;
         bad_count  = 0;
      endfunction

      function int unsigned fit_size(int unsigned v, int unsigned limit);
         if (v < icv_pkg::MIN_SIZE) return icv_pkg::MIN_SIZE;
         if (v > limit) return limit;
         return v;
      endfunction

      function void set_reg(icv_pkg::csr_index_type idx, logic [DATA_W-1:0] value);
         case (idx)
            icv_pkg::CSR_COEF_TOP:     kernel_rows[0] = value;
            icv_pkg::CSR_COEF_MID:     kernel_rows[1] = value;
            icv_pkg::CSR_COEF_BOTTOM:  kernel_rows[2] = value;
            icv_pkg::CSR_FRAME_WIDTH:  width_raw = 32'(value[icv_pkg::FRAME_WIDTH_W-1:0]);
            icv_pkg::CSR_FRAME_HEIGHT: height_raw = 32'(value[icv_pkg::FRAME_HEIGHT_W-1:0]);
            default: ;
         endcase
      endfunction

      function void take_pixel(icv_pkg::pixel_type px);
         int unsigned                 w, h, c, r;
         int                          k, l;
         bit                          end_col, end_row;
         longint                      acc;
         logic [icv_pkg::COEF_W-1:0]  coef;
         filtered_pixel_type          res;
         w = fit_size(width_raw, icv_pkg::MAX_WIDTH);
         h = fit_size(height_raw, icv_pkg::MAX_HEIGHT);
         c = col % icv_pkg::MAX_WIDTH;
         r = row;
         end_col = (c >= w - 1);
         end_row = (r >= h - 1);
         for (k = 0; k < icv_pkg::KERNEL_SIZE; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
         end
         win[0][2] = older_line[c];
         win[1][2] = prior_line[c];
         win[2][2] = px;
         older_line[c] = prior_line[c];
         prior_line[c] = px;
         if (r >= 2 && c >= 2) begin
            acc = 0;
            for (k = 0; k < icv_pkg::KERNEL_SIZE; k++) begin
               for (l = 0; l < icv_pkg::KERNEL_SIZE; l++) begin
                  coef = kernel_rows[k][icv_pkg::COEF_W*l +: icv_pkg::COEF_W];
                  acc += longint'($signed(coef)) * longint'(win[k][l]);
               end
            end
            // arithmetic shift floors negative sums
            acc = acc >>> icv_pkg::FRAC_BITS;
            res.row   = ROW_W'(r - 1);
            res.col   = COL_W'(c - 1);
            res.value = (acc < 0) ? 8'd0 : (acc > 255) ? 8'd255 :
                        acc[icv_pkg::PIXEL_W-1:0];
            res.last  = end_col && end_row;
            due_pixels.push_back(res);
         end
         if (end_col) begin
            col = 0;
            row = end_row ? 0 : r + 1;
         end else begin
            col = c + 1;
         end
      endfunction

      function void note_fault(string why, filtered_pixel_type want,
                               filtered_pixel_type got);
         bad_count++;
         if (bad_count <= MAX_REPORTS) begin
            $display("%s: expected row %0d col %0d pixel %0d last %0d", why,
                     want.row, want.col, want.value, want.last);
            $display("   got row %0d col %0d pixel %0d last %0d",
                     got.row, got.col, got.value, got.last);
         end
      endfunction

      function void match_output(filtered_pixel_type got);
         filtered_pixel_type want;
         if (due_pixels.size() == 0) begin
            note_fault("result with none outstanding", '0, got);
            return;
         end
         want = due_pixels.pop_front();
         if (got.row !== want.row || got.col !== want.col ||
             got.value !== want.value || got.last !== want.last) begin
            note_fault("mismatch", want, got);
         end
      endfunction

      function int unsigned pending();
         return due_pixels.size();
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   icv_pkg::pixel_type                req_pixel_in = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [ROW_W-1:0]                  rsp_out_row;
   logic [COL_W-1:0]                  rsp_out_col;
   icv_pkg::pixel_type                rsp_pixel_out;
   logic                              rsp_last;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [icv_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [DATA_W-1:0]                 csr_data = '0;

   pixel_filter_check board = new();
   int unsigned       send_calm = 0;
   int unsigned       take_calm = 0;
   int unsigned       cycles = 0;

   image_convolution_3x3 dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // idle length per transfer, with occasional runs of back-to-back transfers
   function automatic int unsigned draw_wait(inout int unsigned calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) begin
         calm = $urandom_range(16, 64);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   function automatic icv_pkg::pixel_type any_pixel();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return icv_pkg::pixel_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] any_kernel_row();
      logic [DATA_W-1:0] bits;
      int                v;
      int                l;
      for (l = 0; l < icv_pkg::KERNEL_SIZE; l++) begin
         case ($urandom_range(0, 7))
            0: v = $urandom_range(0, 16'hFFFF);
            1: v = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            default: v = int'($urandom_range(0, 256)) - 96;
         endcase
         bits[icv_pkg::COEF_W*l +: icv_pkg::COEF_W] = v[icv_pkg::COEF_W-1:0];
      end
      return bits;
   endfunction

   task automatic write_reg(icv_pkg::csr_index_type idx, logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.set_reg(idx, value);
   endtask

   task automatic push_pixel(icv_pkg::pixel_type px);
      int unsigned gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= px;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.take_pixel(px);
   endtask

   // wait out every expected result plus the pipeline depth
   task automatic settle();
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : result_side
      int unsigned        hold;
      filtered_pixel_type got;
      forever begin
         hold = draw_wait(take_calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.row   = rsp_out_row;
         got.col   = rsp_out_col;
         got.value = rsp_pixel_out;
         got.last  = rsp_last;
         board.match_output(got);
      end
   end

   initial begin : pixel_side
      icv_pkg::pixel_type frame_a [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255,
                                          8'd255, 8'd0, 8'd255, 8'd0};
      int unsigned sent;
      int unsigned burst;
      int          i;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sizes below range saturate to 3x3; identity kernel
      write_reg(icv_pkg::CSR_COEF_TOP, '0);
      write_reg(icv_pkg::CSR_COEF_MID, 48'h0000_0100_0000);
      write_reg(icv_pkg::CSR_COEF_BOTTOM, '0);
      write_reg(icv_pkg::CSR_FRAME_WIDTH, DATA_W'(0));
      write_reg(icv_pkg::CSR_FRAME_HEIGHT, DATA_W'(0));
      csr_valid <= 1'b0;
      for (i = 0; i < 9; i++) push_pixel(frame_a[i]);
      req_valid <= 1'b0;
      settle();

      // coefficient extremes, height above range, then shrink both mid-frame
      write_reg(icv_pkg::CSR_COEF_TOP, 48'hFFFF_FFFF_FFFF);
      write_reg(icv_pkg::CSR_COEF_MID, 48'h7FFF_0200_8000);
      write_reg(icv_pkg::CSR_COEF_BOTTOM, 48'h0000_0080_0000);
      write_reg(icv_pkg::CSR_FRAME_WIDTH, DATA_W'(4));
      write_reg(icv_pkg::CSR_FRAME_HEIGHT, DATA_W'(13'h1FFF));
      csr_valid <= 1'b0;
      for (i = 0; i < 15; i++) begin
         push_pixel((i % 3 == 0) ? 8'd0 : (i % 3 == 1) ? 8'd255 : any_pixel());
      end
      req_valid <= 1'b0;
      settle();
      write_reg(icv_pkg::CSR_FRAME_WIDTH, DATA_W'(2));
      write_reg(icv_pkg::CSR_FRAME_HEIGHT, DATA_W'(3));
      csr_valid <= 1'b0;
      push_pixel(any_pixel());
      req_valid <= 1'b0;
      settle();

      // width above range saturates to the widest row; the row is cut short
      write_reg(icv_pkg::CSR_COEF_TOP, any_kernel_row());
      write_reg(icv_pkg::CSR_COEF_MID, any_kernel_row());
      write_reg(icv_pkg::CSR_COEF_BOTTOM, any_kernel_row());
      write_reg(icv_pkg::CSR_FRAME_WIDTH, DATA_W'(11'h7FF));
      write_reg(icv_pkg::CSR_FRAME_HEIGHT, DATA_W'(3));
      csr_valid <= 1'b0;
      repeat (WIDE_PIXELS) push_pixel(any_pixel());
      req_valid <= 1'b0;
      settle();
      write_reg(icv_pkg::CSR_FRAME_WIDTH, DATA_W'(4));
      csr_valid <= 1'b0;
      repeat (9) push_pixel(any_pixel());
      req_valid <= 1'b0;
      settle();

      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         if (board.col == 0 && board.row == 0) begin
            if ($urandom_range(0, 2) != 0) begin
               case ($urandom_range(0, 5))
                  0: write_reg(icv_pkg::CSR_FRAME_WIDTH, DATA_W'($urandom_range(0, 2)));
                  1: write_reg(icv_pkg::CSR_FRAME_WIDTH, DATA_W'($urandom_range(17, 40)));
                  default: write_reg(icv_pkg::CSR_FRAME_WIDTH,
                                     DATA_W'($urandom_range(3, 16)));
               endcase
               case ($urandom_range(0, 7))
                  0: write_reg(icv_pkg::CSR_FRAME_HEIGHT, DATA_W'($urandom_range(0, 2)));
                  1: write_reg(icv_pkg::CSR_FRAME_HEIGHT,
                               ($urandom_range(0, 1) != 0) ? DATA_W'(icv_pkg::MAX_HEIGHT)
                                                           : DATA_W'(13'h1FFF));
                  2: write_reg(icv_pkg::CSR_FRAME_HEIGHT,
                               DATA_W'($urandom_range(9, 13'h1FFF)));
                  default: write_reg(icv_pkg::CSR_FRAME_HEIGHT,
                                     DATA_W'($urandom_range(3, 8)));
               endcase
            end
         end else begin
            // mid-frame the row may only get shorter, so the line store
            // never feeds a result from an entry written only once
            if ($urandom_range(0, 3) == 0) begin
               write_reg(icv_pkg::CSR_FRAME_WIDTH,
                         DATA_W'($urandom_range(0, board.fit_size(board.width_raw,
                                                                 icv_pkg::MAX_WIDTH))));
            end
            if ($urandom_range(0, 3) == 0) begin
               write_reg(icv_pkg::CSR_FRAME_HEIGHT, DATA_W'($urandom_range(0, 12)));
            end
         end
         if ($urandom_range(0, 2) == 0) begin
            write_reg(icv_pkg::CSR_COEF_TOP, any_kernel_row());
            write_reg(icv_pkg::CSR_COEF_MID, any_kernel_row());
            write_reg(icv_pkg::CSR_COEF_BOTTOM, any_kernel_row());
         end
         csr_valid <= 1'b0;
         burst = $urandom_range(1, 80);
         repeat (burst) push_pixel(any_pixel());
         req_valid <= 1'b0;
         sent += burst;
         settle();
      end

      if (board.bad_count == 0 && board.pending() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

FILE: image_convolution_3x3.f
+incdir+sv
sv/icv_pkg.sv
sv/icv_ram.sv
sv/icv_csr.sv
sv/icv_mac.sv
sv/image_convolution_3x3.sv
bench/testbench.sv
